// ----- src/ipv4fg_pkg.sv -----
// Shared types, constants and command/status structs for the IPv4 fragment header generator.
`timescale 1ns / 1ps
`default_nettype none
package ipv4fg_pkg;

  localparam logic [15:0] HDR_BYTES  = 16'd20;
  localparam int unsigned DF_BIT     = 14;
  localparam int unsigned MF_BIT     = 13;
  localparam logic [15:0] FLAG_DF    = 16'h4000;
  localparam logic [7:0]  LOCAL_VIHL = 8'h45;
  localparam logic [15:0] MIN_LINK   = 16'd1048;
  localparam logic [15:0] LINK_RESET = 16'd1500;

  typedef enum logic [2:0] {
    ST_WHOLE = 3'd0,
    ST_FRAG  = 3'd1,
    ST_SHORT = 3'd2,
    ST_OVER  = 3'd3,
    ST_DF    = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_desc;
    logic    load_drop;
    status_t drop_code;
    logic    setup;
    logic    sum;
    logic    load_hdr;
    logic    advance;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic short_drop;
    logic oversize;
    logic fits;
    logic df_set;
    logic hdr_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- src/ipv4fg_ifs.sv -----
// Channel interfaces: packet descriptor, header result and link size config.
`timescale 1ns / 1ps
`default_nettype none
interface ipv4fg_desc_if;
  logic        valid;
  logic        ready;
  logic        gating;
  logic        tso;
  logic [16:0] packet_len;
  logic [7:0]  hdr_vihl;
  logic [7:0]  tos_value;
  logic [7:0]  ttl_value;
  logic [15:0] hdr_total_len;
  logic [15:0] hdr_ident;
  logic [15:0] hdr_frag_field;
  logic [7:0]  proto_value;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;

  modport source (
    output valid, gating, tso, packet_len, hdr_vihl, tos_value, ttl_value,
           hdr_total_len, hdr_ident, hdr_frag_field, proto_value, src_addr, dst_addr,
    input  ready
  );
  modport sink (
    input  valid, gating, tso, packet_len, hdr_vihl, tos_value, ttl_value,
           hdr_total_len, hdr_ident, hdr_frag_field, proto_value, src_addr, dst_addr,
    output ready
  );
endinterface

interface ipv4fg_hdr_if;
  logic                valid;
  logic                ready;
  ipv4fg_pkg::status_t status;
  logic [7:0]          out_vihl;
  logic [7:0]          out_tos;
  logic [7:0]          out_ttl;
  logic [15:0]         out_total_len;
  logic [15:0]         out_ident;
  logic [15:0]         out_frag_field;
  logic [15:0]         out_checksum;
  logic [15:0]         payload_offset;
  logic                last;

  modport source (
    output valid, status, out_vihl, out_tos, out_ttl, out_total_len, out_ident,
           out_frag_field, out_checksum, payload_offset, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_vihl, out_tos, out_ttl, out_total_len, out_ident,
           out_frag_field, out_checksum, payload_offset, last,
    output ready
  );
endinterface

interface ipv4fg_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- src/ipv4fg_ctrl.sv -----
// Sequencing state machine: classify, set up, checksum base, one header per fragment.
`timescale 1ns / 1ps
`default_nettype none
module ipv4fg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 desc_valid,
  output logic                      desc_ready,
  output logic                      hdr_valid,
  input  wire logic                 hdr_ready,
  input  wire ipv4fg_pkg::dp_stat_t stat,
  output ipv4fg_pkg::dp_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_CLASSIFY = 5'b00010,
    S_SUM      = 5'b00100,
    S_HDR      = 5'b01000,
    S_OUT      = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // no request is taken while reset is held
  assign desc_ready = (state == S_IDLE) && !rst;
  assign hdr_valid  = (state == S_OUT);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.drop_code = ipv4fg_pkg::ST_WHOLE;
    unique case (state)
      S_IDLE: begin
        if (desc_valid) begin
          cmd.load_desc = 1'b1;
          state_next    = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (stat.short_drop) begin
          cmd.load_drop = 1'b1;
          cmd.drop_code = ipv4fg_pkg::ST_SHORT;
          state_next    = S_OUT;
        end else if (stat.oversize) begin
          cmd.load_drop = 1'b1;
          cmd.drop_code = ipv4fg_pkg::ST_OVER;
          state_next    = S_OUT;
        end else if (!stat.fits && stat.df_set) begin
          cmd.load_drop = 1'b1;
          cmd.drop_code = ipv4fg_pkg::ST_DF;
          state_next    = S_OUT;
        end else begin
          cmd.setup  = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_HDR;
      end
      S_HDR: begin
        cmd.load_hdr = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (hdr_ready) begin
          if (stat.hdr_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_HDR;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/ipv4fg_dp.sv -----
// Datapath: request registers, ident counter, segment walker, checksum and result register.
`timescale 1ns / 1ps
`default_nettype none
module ipv4fg_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ipv4fg_pkg::dp_cmd_t cmd,
  output ipv4fg_pkg::dp_stat_t     stat,
  // config write
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_data,
  // request fields
  input  wire logic                gating,
  input  wire logic                tso,
  input  wire logic [16:0]         packet_len,
  input  wire logic [7:0]          hdr_vihl,
  input  wire logic [7:0]          tos_value,
  input  wire logic [7:0]          ttl_value,
  input  wire logic [15:0]         hdr_total_len,
  input  wire logic [15:0]         hdr_ident,
  input  wire logic [15:0]         hdr_frag_field,
  input  wire logic [7:0]          proto_value,
  input  wire logic [31:0]         src_addr,
  input  wire logic [31:0]         dst_addr,
  // result fields
  output ipv4fg_pkg::status_t      status,
  output logic [7:0]               out_vihl,
  output logic [7:0]               out_tos,
  output logic [7:0]               out_ttl,
  output logic [15:0]              out_total_len,
  output logic [15:0]              out_ident,
  output logic [15:0]              out_frag_field,
  output logic [15:0]              out_checksum,
  output logic [15:0]              payload_offset,
  output logic                     last
);

  // captured request
  logic        r_gating;
  logic        r_tso;
  logic [16:0] r_len;
  logic [7:0]  r_vihl_in;
  logic [7:0]  r_tos;
  logic [7:0]  r_ttl;
  logic [15:0] r_htot;
  logic [15:0] r_hid;
  logic [15:0] r_hfrag;
  logic [7:0]  r_proto;
  logic [31:0] r_src;
  logic [31:0] r_dst;

  logic [15:0] link_max;
  logic [15:0] next_ident;

  // per-packet working registers
  logic        whole;
  logic [7:0]  vihl_s;
  logic [15:0] id_s;
  logic [15:0] tot_whole;
  logic [15:0] seglen;
  logic [15:0] base;
  logic [16:0] end_pos;
  logic [16:0] off;
  logic [18:0] base_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_max <= ipv4fg_pkg::LINK_RESET;
    end else if (cfg_we) begin
      link_max <= (cfg_data < ipv4fg_pkg::MIN_LINK) ? ipv4fg_pkg::MIN_LINK : cfg_data;
    end
  end

  // classification
  logic [16:0] eff_len;
  logic [15:0] ident_inc;
  logic [15:0] link_data;

  assign eff_len   = r_gating ? {1'b0, r_htot} : r_len;
  assign ident_inc = next_ident + 16'd1;
  assign link_data = link_max - ipv4fg_pkg::HDR_BYTES;

  always_comb begin
    stat.short_drop = r_gating && ({1'b0, r_htot} > r_len);
    stat.oversize   = eff_len[16];
    stat.fits       = r_tso || (eff_len <= {1'b0, link_max});
    stat.df_set     = r_hfrag[ipv4fg_pkg::DF_BIT];
    stat.hdr_last   = last;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_desc) begin
      r_gating  <= gating;
      r_tso     <= tso;
      r_len     <= packet_len;
      r_vihl_in <= hdr_vihl;
      r_tos     <= tos_value;
      r_ttl     <= ttl_value;
      r_htot    <= hdr_total_len;
      r_hid     <= hdr_ident;
      r_hfrag   <= hdr_frag_field;
      r_proto   <= proto_value;
      r_src     <= src_addr;
      r_dst     <= dst_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_ident <= '0;
    end else if (cmd.setup && !r_gating) begin
      next_ident <= ident_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      whole     <= stat.fits;
      vihl_s    <= r_gating ? r_vihl_in : ipv4fg_pkg::LOCAL_VIHL;
      id_s      <= r_gating ? r_hid : ident_inc;
      tot_whole <= eff_len[15:0];
      seglen    <= {link_data[15:3], 3'b000};
      base      <= r_gating ? {r_hfrag[12:0], 3'b000} : 16'd0;
      // data bytes after the header, appended to the original offset
      end_pos   <= (r_gating ? {1'b0, r_hfrag[12:0], 3'b000} : 17'd0)
                   + {1'b0, eff_len[15:0] - ipv4fg_pkg::HDR_BYTES};
      off       <= r_gating ? {1'b0, r_hfrag[12:0], 3'b000} : 17'd0;
    end else if (cmd.advance) begin
      off <= off + {1'b0, seglen};
    end
  end

  // fixed part of the header checksum: everything but length and flags/offset
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      base_sum <= {3'b000, vihl_s, r_tos} + {3'b000, id_s} + {3'b000, r_ttl, r_proto}
                  + {3'b000, r_src[31:16]} + {3'b000, r_src[15:0]}
                  + {3'b000, r_dst[31:16]} + {3'b000, r_dst[15:0]};
    end
  end

  // current fragment
  logic        fin;
  logic [16:0] remain;
  logic [15:0] seg;
  logic        mf;
  logic [15:0] tot;
  logic [15:0] frag;
  logic [19:0] ck_full;
  logic [16:0] ck_fold1;
  logic [16:0] ck_fold2;
  logic [16:0] rel_off;

  always_comb begin
    fin      = ({1'b0, off} + {2'b00, seglen}) >= {1'b0, end_pos};
    remain   = end_pos - off;
    seg      = fin ? remain[15:0] : seglen;
    mf       = fin ? (r_gating && r_hfrag[ipv4fg_pkg::MF_BIT]) : 1'b1;
    rel_off  = off - {1'b0, base};
    if (whole) begin
      tot  = tot_whole;
      frag = r_gating ? r_hfrag : ipv4fg_pkg::FLAG_DF;
    end else begin
      tot  = seg + ipv4fg_pkg::HDR_BYTES;
      frag = {2'b00, mf, off[15:3]};   // offset wraps to 13 bits
    end
    ck_full  = {1'b0, base_sum} + {4'h0, tot} + {4'h0, frag};
    ck_fold1 = {1'b0, ck_full[15:0]} + {13'd0, ck_full[19:16]};
    ck_fold2 = {1'b0, ck_fold1[15:0]} + {16'd0, ck_fold1[16]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_drop) begin
      status         <= cmd.drop_code;
      out_vihl       <= '0;
      out_tos        <= '0;
      out_ttl        <= '0;
      out_total_len  <= '0;
      out_ident      <= '0;
      out_frag_field <= '0;
      out_checksum   <= '0;
      payload_offset <= '0;
      last           <= 1'b1;
    end else if (cmd.load_hdr) begin
      status         <= whole ? ipv4fg_pkg::ST_WHOLE : ipv4fg_pkg::ST_FRAG;
      out_vihl       <= vihl_s;
      out_tos        <= r_tos;
      out_ttl        <= r_ttl;
      out_total_len  <= tot;
      out_ident      <= id_s;
      out_frag_field <= frag;
      out_checksum   <= ~ck_fold2[15:0];
      payload_offset <= whole ? 16'd0 : rel_off[15:0];
      last           <= whole || fin;
    end
  end

endmodule
`default_nettype wire

// ----- src/ipv4_fragment_header_generator.sv -----
// Top level of the IPv4 fragment header generator.
//
// Channels: desc takes one packet descriptor per request, hdr returns the
// headers to send, cfg writes the largest packet size the link carries
// (values below 1048 are raised to 1048; cfg is ready outside reset and must
// only be written while the block is idle).
// Each request yields one result (whole header or a drop/refusal status)
// or a train of fragment headers, the final one marked by last.
// Sequence: a request is first classified; a drop result then goes straight
// to the output, while a whole header or first fragment passes through the
// checksum-base and header states first; each further fragment is built in
// the header state again after the previous one is taken. desc is ready
// again the cycle after the last result is taken. The controller sequence
// builds one header and checksum at a time.
// A stalled hdr holds its result; nothing new is taken meanwhile.
// Reset (rst, synchronous) returns to idle, sets the link size to 1500 and
// the identification counter to zero.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_fragment_header_generator (
  input wire logic       clk,
  input wire logic       rst,
  ipv4fg_desc_if.sink    desc,
  ipv4fg_hdr_if.source   hdr,
  ipv4fg_cfg_if.sink     cfg
);

  ipv4fg_pkg::dp_cmd_t  cmd;
  ipv4fg_pkg::dp_stat_t stat;

  assign cfg.ready = !rst;

  ipv4fg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc.valid),
    .desc_ready (desc.ready),
    .hdr_valid  (hdr.valid),
    .hdr_ready  (hdr.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ipv4fg_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg.valid && cfg.ready),
    .cfg_data       (cfg.data),
    .gating         (desc.gating),
    .tso            (desc.tso),
    .packet_len     (desc.packet_len),
    .hdr_vihl       (desc.hdr_vihl),
    .tos_value      (desc.tos_value),
    .ttl_value      (desc.ttl_value),
    .hdr_total_len  (desc.hdr_total_len),
    .hdr_ident      (desc.hdr_ident),
    .hdr_frag_field (desc.hdr_frag_field),
    .proto_value    (desc.proto_value),
    .src_addr       (desc.src_addr),
    .dst_addr       (desc.dst_addr),
    .status         (hdr.status),
    .out_vihl       (hdr.out_vihl),
    .out_tos        (hdr.out_tos),
    .out_ttl        (hdr.out_ttl),
    .out_total_len  (hdr.out_total_len),
    .out_ident      (hdr.out_ident),
    .out_frag_field (hdr.out_frag_field),
    .out_checksum   (hdr.out_checksum),
    .payload_offset (hdr.payload_offset),
    .last           (hdr.last)
  );

  // never takes a request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    desc.ready |-> !hdr.valid)
    else $error("request taken while result pending");

  a_classify_gap: assert property (@(posedge clk) disable iff (rst)
    desc.valid && desc.ready |=> !hdr.valid && !desc.ready)
    else $error("result or request right after accept");

  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    hdr.valid && (hdr.status == ipv4fg_pkg::ST_SHORT || hdr.status == ipv4fg_pkg::ST_OVER
                  || hdr.status == ipv4fg_pkg::ST_DF) |-> hdr.last)
    else $error("drop result without last");

  a_mid_frag_mf: assert property (@(posedge clk) disable iff (rst)
    hdr.valid && !hdr.last |-> hdr.status == ipv4fg_pkg::ST_FRAG && hdr.out_frag_field[13])
    else $error("non-final result is not a fragment with MF");

endmodule
`default_nettype wire
